/* design/rgb_convolution_3x3_core_assert.svh */
// Assertion macros shared by the convolution core.
`ifndef RGB_CONVOLUTION_3X3_CORE_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_CORE_ASSERT_SVH

// cond must never hold outside reset
`define RGBC_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// a implies b in the same cycle
`define RGBC_ASSERT_IMPLY(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);

`endif

/* design/rgbc_pkg.sv */
// Shared types and constants of the RGB 3x3 convolution core.
`timescale 1ns / 1ps
package rgbc_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned SIZE_REG_W  = 11;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_KERNEL_FIRST  = 3'd2,
		REG_KERNEL_MIDDLE = 3'd3,
		REG_KERNEL_LAST   = 3'd4
	} reg_idx_t;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic [CFG_DATA_W-1:0] KERNEL_FIRST_RST  = 24'h010001;
	localparam logic [CFG_DATA_W-1:0] KERNEL_MIDDLE_RST = 24'h00FC00;
	localparam logic [CFG_DATA_W-1:0] KERNEL_LAST_RST   = 24'h010001;

	typedef logic [23:0] pixel_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] coef_first;
		logic [CFG_DATA_W-1:0] coef_middle;
		logic [CFG_DATA_W-1:0] coef_last;
	} kernel_t;

	// one classified beat from front to back
	typedef struct packed {
		logic   is_pixel;
		logic   emit;
		logic   inner;
		logic   frame_end;
		pixel_t up;
		pixel_t mid;
		pixel_t pix;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} result_t;

	localparam int unsigned ITEM_QDEPTH = 4;
	localparam int unsigned ITEM_CNT_W  = $clog2(ITEM_QDEPTH + 1);
	localparam int unsigned RES_QDEPTH  = 4;
	localparam int unsigned RES_CNT_W   = $clog2(RES_QDEPTH + 1);

endpackage

/* design/rgbc_fifo.sv */
// Small register FIFO with fill count.
`timescale 1ns / 1ps
module rgbc_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4,
	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int unsigned CNTW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic [CNTW-1:0]  count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CNTW'(wr_en) - CNTW'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* design/rgbc_front.sv */
// Front end: frame counters, request classification and the line store.
`timescale 1ns / 1ps
module rgbc_front #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 1024,
	localparam int unsigned CW = $clog2(MAX_WIDTH),
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              req_type,
	input  rgbc_pkg::pixel_t                  pix,
	input  logic [WW-1:0]                     width,
	input  logic [HW-1:0]                     height,
	input  logic                              restart,
	input  logic [rgbc_pkg::ITEM_CNT_W-1:0]   q_count,
	output logic                              item_valid,
	output rgbc_pkg::item_t                   item
);

	logic [CW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic [WW-1:0] drain_q;

	logic             valid_s1;
	logic             is_pix_s1;
	logic             emit_s1;
	logic             inner_s1;
	logic             fe_s1;
	rgbc_pkg::pixel_t pix_s1;
	logic [CW-1:0]    col_s1;
	logic [47:0]      rd_s1;

	// entry holds {upper line, middle line}
	logic [47:0] line_mem_q [MAX_WIDTH];

	logic [rgbc_pkg::ITEM_CNT_W:0] q_fill;
	logic          accept;
	logic          pix_ok;
	logic          pix_take;
	logic          drain_take;
	logic [WW-1:0] col_inc;
	logic [HW-1:0] row_inc;
	logic          emit;
	logic          inner;
	logic          last_drain;

	assign q_fill = {1'b0, q_count} + (rgbc_pkg::ITEM_CNT_W + 1)'(valid_s1);
	assign full   = q_fill >= (rgbc_pkg::ITEM_CNT_W + 1)'(rgbc_pkg::ITEM_QDEPTH);
	assign accept = push && !full;

	assign pix_ok     = row_q < height;
	assign pix_take   = accept && (req_type == rgbc_pkg::REQ_PIXEL) && pix_ok;
	assign drain_take = accept && (req_type == rgbc_pkg::REQ_DRAIN) && !pix_ok;

	assign col_inc    = WW'(col_q) + WW'(1);
	assign row_inc    = row_q + HW'(1);
	assign emit       = (row_q >= HW'(2)) || ((row_q == HW'(1)) && (col_q != '0));
	assign inner      = (col_q >= CW'(2)) && (row_q >= HW'(2));
	assign last_drain = drain_q == width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pix_take || drain_take;
			priority if (restart) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= '0;
			end else if (pix_take) begin
				if (col_inc >= width) begin
					col_q <= '0;
					row_q <= row_inc;
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end else if (drain_take) begin
				if (last_drain) begin
					col_q   <= '0;
					row_q   <= '0;
					drain_q <= '0;
				end else begin
					drain_q <= drain_q + WW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take || drain_take) begin
			is_pix_s1 <= pix_take;
			emit_s1   <= pix_take ? emit : 1'b1;
			inner_s1  <= pix_take && inner;
			fe_s1     <= drain_take && last_drain;
			pix_s1    <= pix;
			col_s1    <= col_q;
		end
	end

	// read at accept; the registered read data is written back with the new pixel
	always_ff @(posedge clk) begin
		if (pix_take) begin
			rd_s1 <= line_mem_q[col_q];
		end
		if (valid_s1 && is_pix_s1) begin
			line_mem_q[col_s1] <= {rd_s1[23:0], pix_s1};
		end
	end

	assign item_valid     = valid_s1;
	assign item.is_pixel  = is_pix_s1;
	assign item.emit      = emit_s1;
	assign item.inner     = inner_s1;
	assign item.frame_end = fe_s1;
	assign item.up        = rd_s1[47:24];
	assign item.mid       = rd_s1[23:0];
	assign item.pix       = pix_s1;

endmodule

/* design/rgbc_back.sv */
// Back end: 3x3 window, kernel products and channel sums.
`timescale 1ns / 1ps
module rgbc_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  rgbc_pkg::item_t                  item,
	output logic                             item_pop,
	input  rgbc_pkg::kernel_t                kernel,
	input  logic [rgbc_pkg::RES_CNT_W-1:0]   res_count,
	output logic                             res_push,
	output rgbc_pkg::result_t                res
);

	rgbc_pkg::pixel_t win_q [3][3];
	logic             emit_s1;
	logic             inner_s1;
	logic             fe_s1;
	logic [7:0]       prod_s2 [3][9];
	logic             emit_s2;
	logic             inner_s2;
	logic             fe_s2;

	logic [23:0] kern_cols [3];
	logic [7:0]  prod [3][9];
	logic [7:0]  sum [3];
	logic [rgbc_pkg::RES_CNT_W:0] in_flight;

	assign in_flight = {1'b0, res_count} + (rgbc_pkg::RES_CNT_W + 1)'(emit_s1)
		+ (rgbc_pkg::RES_CNT_W + 1)'(emit_s2);
	assign item_pop  = item_valid && (in_flight < (rgbc_pkg::RES_CNT_W + 1)'(rgbc_pkg::RES_QDEPTH));

	assign kern_cols[0] = kernel.coef_first;
	assign kern_cols[1] = kernel.coef_middle;
	assign kern_cols[2] = kernel.coef_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			emit_s1 <= item_pop && item.emit;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop && item.is_pixel) begin
			win_q[0]    <= win_q[1];
			win_q[1]    <= win_q[2];
			win_q[2][0] <= item.up;
			win_q[2][1] <= item.mid;
			win_q[2][2] <= item.pix;
		end
		if (item_pop) begin
			inner_s1 <= item.inner;
			fe_s1    <= item.frame_end;
		end
		prod_s2  <= prod;
		inner_s2 <= inner_s1;
		fe_s2    <= fe_s1;
	end

	// only the low byte of each product survives the wrapping sum
	always_comb begin
		logic [15:0] mul;
		mul = '0;
		for (int ch = 0; ch < 3; ch++) begin
			for (int h = 0; h < 3; h++) begin
				for (int v = 0; v < 3; v++) begin
					mul = {8'd0, kern_cols[h][8*v +: 8]} * {8'd0, win_q[h][v][8*ch +: 8]};
					prod[ch][h*3 + v] = mul[7:0];
				end
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int k = 0; k < 9; k++) begin
				sum[ch] = sum[ch] + prod_s2[ch][k];
			end
		end
	end

	assign res_push      = emit_s2;
	assign res.red       = inner_s2 ? sum[0] : 8'd0;
	assign res.green     = inner_s2 ? sum[1] : 8'd0;
	assign res.blue      = inner_s2 ? sum[2] : 8'd0;
	assign res.frame_end = fe_s2;

endmodule

/* design/rgb_convolution_3x3_core.sv */
// Top level of the streaming RGB 3x3 convolution core.
//
//  channel   direction  handshake                beat
//  input     in         push / full              req_type, red, green, blue
//  result    out        pop / empty              out_red, out_green, out_blue, frame_end
//  config    in         cfg_wr_en (no wait)      cfg_index, cfg_data
//
// One beat per cycle sustained while full stays low; a result reaches the result queue
// through the line store read stage, the item queue and the product/sum stages.
// Results of a row lag the input by frame_width+1 pixels; drain beats flush them.
// Reset clears counters, queues, flags and config; data and line store are kept.
// Either side may stall on its own: the item queue and the result queue absorb it.
`timescale 1ns / 1ps
`include "rgb_convolution_3x3_core_assert.svh"
module rgb_convolution_3x3_core #(
	parameter int unsigned MAX_WIDTH = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                req_type,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	output logic                                empty,
	input  logic                                pop,
	output logic [7:0]                          out_red,
	output logic [7:0]                          out_green,
	output logic [7:0]                          out_blue,
	output logic                                frame_end,
	input  logic                                cfg_wr_en,
	input  logic [rgbc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rgbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned W_RST_I = (MAX_WIDTH < 80) ? MAX_WIDTH : 80;
	localparam int unsigned H_RST_I = (MAX_HEIGHT < 80) ? MAX_HEIGHT : 80;
	localparam logic [WW-1:0] W_RST = WW'(W_RST_I);
	localparam logic [HW-1:0] H_RST = HW'(H_RST_I);
	localparam int unsigned ITEM_W = $bits(rgbc_pkg::item_t);
	localparam int unsigned RES_W  = $bits(rgbc_pkg::result_t);

	logic [WW-1:0]     width_q;
	logic [HW-1:0]     height_q;
	rgbc_pkg::kernel_t kernel_q;

	logic [31:0]   size_val;
	logic [WW-1:0] sat_w;
	logic [HW-1:0] sat_h;
	logic          restart;

	rgbc_pkg::pixel_t  pix;
	logic              f_valid;
	rgbc_pkg::item_t   f_item;
	logic [ITEM_W-1:0] q_rd;
	rgbc_pkg::item_t   q_item;
	logic              q_empty;
	logic              q_pop;
	logic [rgbc_pkg::ITEM_CNT_W-1:0] q_count;

	logic              res_push;
	rgbc_pkg::result_t res_in;
	logic [RES_W-1:0]  res_rd;
	rgbc_pkg::result_t res_out;
	logic [rgbc_pkg::RES_CNT_W-1:0] res_count;

	assign size_val = 32'(cfg_data[rgbc_pkg::SIZE_REG_W-1:0]);

	always_comb begin
		if (size_val < 32'd3) begin
			sat_w = WW'(3);
		end else if (size_val > 32'(MAX_WIDTH)) begin
			sat_w = WW'(MAX_WIDTH);
		end else begin
			sat_w = WW'(size_val);
		end
		if (size_val < 32'd3) begin
			sat_h = HW'(3);
		end else if (size_val > 32'(MAX_HEIGHT)) begin
			sat_h = HW'(MAX_HEIGHT);
		end else begin
			sat_h = HW'(size_val);
		end
	end

	assign restart = cfg_wr_en
		&& ((cfg_index == rgbc_pkg::REG_FRAME_WIDTH) || (cfg_index == rgbc_pkg::REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q              <= W_RST;
			height_q             <= H_RST;
			kernel_q.coef_first  <= rgbc_pkg::KERNEL_FIRST_RST;
			kernel_q.coef_middle <= rgbc_pkg::KERNEL_MIDDLE_RST;
			kernel_q.coef_last   <= rgbc_pkg::KERNEL_LAST_RST;
		end else if (cfg_wr_en) begin
			unique case (rgbc_pkg::reg_idx_t'(cfg_index))
				rgbc_pkg::REG_FRAME_WIDTH:   width_q              <= sat_w;
				rgbc_pkg::REG_FRAME_HEIGHT:  height_q             <= sat_h;
				rgbc_pkg::REG_KERNEL_FIRST:  kernel_q.coef_first  <= cfg_data;
				rgbc_pkg::REG_KERNEL_MIDDLE: kernel_q.coef_middle <= cfg_data;
				rgbc_pkg::REG_KERNEL_LAST:   kernel_q.coef_last   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign pix = {blue, green, red};

	rgbc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.req_type   (req_type),
		.pix        (pix),
		.width      (width_q),
		.height     (height_q),
		.restart    (restart),
		.q_count    (q_count),
		.item_valid (f_valid),
		.item       (f_item)
	);

	rgbc_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (rgbc_pkg::ITEM_QDEPTH)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid),
		.wr_data (f_item),
		.rd_en   (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty),
		.count   (q_count)
	);

	assign q_item = rgbc_pkg::item_t'(q_rd);

	rgbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item       (q_item),
		.item_pop   (q_pop),
		.kernel     (kernel_q),
		.res_count  (res_count),
		.res_push   (res_push),
		.res        (res_in)
	);

	rgbc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (rgbc_pkg::RES_QDEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty),
		.count   (res_count)
	);

	assign res_out   = rgbc_pkg::result_t'(res_rd);
	assign out_red   = res_out.red;
	assign out_green = res_out.green;
	assign out_blue  = res_out.blue;
	assign frame_end = res_out.frame_end;

	`RGBC_ASSERT_IMPLY(a_item_q_room, f_valid, q_count < rgbc_pkg::ITEM_CNT_W'(rgbc_pkg::ITEM_QDEPTH), "item queue overflow")
	`RGBC_ASSERT_IMPLY(a_res_q_room, res_push, res_count < rgbc_pkg::RES_CNT_W'(rgbc_pkg::RES_QDEPTH), "result queue overflow")
	`RGBC_ASSERT_NEVER(a_full_at_depth, (q_count == rgbc_pkg::ITEM_CNT_W'(rgbc_pkg::ITEM_QDEPTH)) && !full, "full low with item queue at depth")

endmodule
